// ----- rtl/assert_macros.svh -----
// Assertion macros used by the plant-step controller.
// No dependencies; the including module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pmsm_pkg.sv -----
// Package for the motor plant step: widths, fixed-point constants,
// step codes, command/status structs and the quarter-sine generator.
// No dependencies.
package pmsm_pkg;

	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam int VOLT_W = 26;
	localparam int CUR_W  = 32;
	localparam int SPD_W  = 40;
	localparam int POS_W  = 48;
	localparam int TURN_W = 56;
	localparam int ACC_W  = 66;
	localparam int OPA_W  = 49;
	localparam int OPB_W  = 33;
	localparam int PP_W   = 58;
	localparam int TMP_W  = 58;
	localparam int IN_W   = 80;
	localparam int OUT_W  = 192;
	localparam int CFG_W  = 32;
	localparam int CFG_AW = 3;

	// Multiplier constants (all fit a 33-bit signed operand)
	localparam logic signed [OPB_W-1:0] K_TURN     = 33'sd2734261104;
	localparam logic signed [OPB_W-1:0] K_PARK     = 33'sd715831462;
	localparam logic signed [OPB_W-1:0] K_PLQ      = 33'sd246289;
	localparam logic signed [OPB_W-1:0] K_FLUX     = 33'sd3163512;
	localparam logic signed [OPB_W-1:0] K_RECIP_KA = 33'sd933926466;
	localparam logic signed [OPB_W-1:0] K_KB_KA    = 33'sd1068452006;
	localparam logic signed [OPB_W-1:0] K_TS_J     = 33'sd95325090;
	localparam logic signed [OPB_W-1:0] K_TS_JM    = 33'sd610080582;
	localparam logic signed [OPB_W-1:0] K_TS_JL    = 33'sd112977886;
	localparam logic signed [OPB_W-1:0] K_TS       = 33'sd6871948;
	localparam logic signed [OPB_W-1:0] K_HALF_TS  = 33'sd3435974;

	// Turn fractions in Q56
	localparam logic [TURN_W-1:0] TURN_THIRD   = 56'd24019198012642645;
	localparam logic [TURN_W-1:0] TURN_QUARTER = 56'd18014398509481984;

	// Configuration register reset values
	localparam logic [29:0] STIFF_RST = 30'd327680000;
	localparam logic [31:0] DAMP_RST  = 32'd858993;
	localparam logic [31:0] FRIC_RST  = 32'd4294967;

	typedef enum logic [CFG_AW-1:0] {
		CFG_TWO_MASS    = 3'd0,
		CFG_LOAD_TORQUE = 3'd1,
		CFG_STIFFNESS   = 3'd2,
		CFG_DAMPING     = 3'd3,
		CFG_FRICTION    = 3'd4
	} cfg_idx_t;

	// Phases within one datapath step
	localparam logic [1:0] PH_LO  = 2'd0;
	localparam logic [1:0] PH_HI  = 2'd1;
	localparam logic [1:0] PH_ACC = 2'd2;
	localparam logic [1:0] PH_WB  = 2'd3;

	// Datapath steps in issue order
	typedef enum logic [5:0] {
		ST_ANGLE, ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3, ST_SIN4, ST_SIN5,
		ST_PD0, ST_PD1, ST_PD2, ST_UD, ST_PQ0, ST_PQ1, ST_PQ2, ST_UQ,
		ST_XR, ST_IDE, ST_EMF, ST_IQE, ST_ID_DRV, ST_ID, ST_IQ_DRV, ST_IQ,
		ST_IA0, ST_IA1, ST_IB0, ST_IB1, ST_T0, ST_T1, ST_T2, ST_TE,
		ST_FR_HI, ST_FR_LO,
		ST_R_SPD, ST_R_POS,
		ST_E_MSPD, ST_E_MPOS, ST_E_LSPD, ST_E_LPOS,
		ST_SH_D_HI, ST_SH_D_LO, ST_SH_K_HI, ST_SH_K_LO
	} step_t;

	typedef struct packed {
		logic       load;
		logic       run;
		logic [1:0] phase;
		step_t      step;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic two_mass;
	} stat_t;

	// sin(pi/2 * x) for x in Q30 [0,1], result Q30, evaluated at elaboration
	function automatic logic [30:0] qsine(input longint x);
		longint x2;
		longint p;
		x2 = (x * x) >>> 30;
		p = 61;
		p = -3864 + ((p * x2) >>> 30);
		p = 172272 + ((p * x2) >>> 30);
		p = -5026995 + ((p * x2) >>> 30);
		p = 85569306 + ((p * x2) >>> 30);
		p = -693598669 + ((p * x2) >>> 30);
		p = 1686629713 + ((p * x2) >>> 30);
		p = (p * x) >>> 30;
		if (p > (64'sd1 <<< 30)) p = 64'sd1 <<< 30;
		if (p < 0) p = 0;
		return p[30:0];
	endfunction

endpackage

// ----- rtl/pmsm_sine_rom.sv -----
// Quarter-wave sine table with registered read.
// Depends on pmsm_pkg for the table generator.
module pmsm_sine_rom #(
	parameter int SINE_TABLE_BITS = pmsm_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [SINE_TABLE_BITS-2:0] addr,
	output logic [30:0]                data
);
	import pmsm_pkg::*;

	localparam int QBITS = SINE_TABLE_BITS - 2;
	localparam int DEPTH = (1 << QBITS) + 1;

	logic [30:0] tbl [DEPTH];
	logic [30:0] data_q;

	// Fill constant entries, one per quarter step
	for (genvar i = 0; i < DEPTH; i++) begin : g_tbl
		assign tbl[i] = qsine(longint'(i) <<< (30 - QBITS));
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= tbl[addr];
		end
	end

	assign data = data_q;

endmodule

// ----- rtl/pmsm_datapath.sv -----
// Datapath of the motor plant step: registers, shared 25x33 multiplier,
// accumulator, write-back logic and sine lookup. Depends on pmsm_pkg, pmsm_sine_rom.
module pmsm_datapath #(
	parameter int SINE_TABLE_BITS = pmsm_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pmsm_pkg::cmd_t               cmd,
	output pmsm_pkg::stat_t              stat,
	input  logic [pmsm_pkg::IN_W-1:0]    in_data,
	input  logic                         cfg_we,
	input  logic [pmsm_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [pmsm_pkg::CFG_W-1:0]   cfg_wdata,
	output logic [pmsm_pkg::OUT_W-1:0]   out_data
);
	import pmsm_pkg::*;

	localparam int QBITS = SINE_TABLE_BITS - 2;
	localparam logic [SINE_TABLE_BITS-2:0] QSIZE = (SINE_TABLE_BITS-1)'(1 << QBITS);
	localparam logic [TURN_W-1:0] ROUND_HALF = TURN_W'(1) << (TURN_W - 1 - SINE_TABLE_BITS);

	localparam int SC_S0 = 0;
	localparam int SC_S1 = 1;
	localparam int SC_S2 = 2;
	localparam int SC_C0 = 3;
	localparam int SC_C1 = 4;
	localparam int SC_C2 = 5;

	localparam logic signed [ACC_W-1:0] MAX32 = (ACC_W'(1) <<< 31) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] MIN32 = -(ACC_W'(1) <<< 31);
	localparam logic signed [ACC_W-1:0] MAX40 = (ACC_W'(1) <<< 39) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] MIN40 = -(ACC_W'(1) <<< 39);

	function automatic logic signed [CUR_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [CUR_W-1:0] r;
		if (v > MAX32) r = MAX32[CUR_W-1:0];
		else if (v < MIN32) r = MIN32[CUR_W-1:0];
		else r = v[CUR_W-1:0];
		return r;
	endfunction

	function automatic logic signed [SPD_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
		logic signed [SPD_W-1:0] r;
		if (v > MAX40) r = MAX40[SPD_W-1:0];
		else if (v < MIN40) r = MIN40[SPD_W-1:0];
		else r = v[SPD_W-1:0];
		return r;
	endfunction

	// Configuration
	logic                     mode_q;
	logic signed [21:0]       tl_q;
	logic [29:0]              stiff_q;
	logic [31:0]              damp_q;
	logic [31:0]              fric_q;

	// Plant state
	logic signed [CUR_W-1:0]  dcur_q, qcur_q, dprev_q, qprev_q, st_q;
	logic signed [SPD_W-1:0]  ms_q, msp_q, ls_q;
	logic signed [POS_W-1:0]  ma_q, la_q;

	// Per-item working registers
	logic signed [VOLT_W-1:0] ua_q, ub_q, uc_q;
	logic [TURN_W-1:0]        t0_q;
	logic signed [CUR_W-1:0]  sc_q [6];
	logic signed [CUR_W-1:0]  ud_q, uq_q, xr_q, ide_q, iqe_q;
	logic signed [CUR_W-1:0]  ia_q, ib_q, ic_q, te_q, net_q;
	logic signed [TMP_W-1:0]  tmp_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PP_W-1:0]   pp_s1;
	logic                     neg_q;

	// Result word
	logic signed [CUR_W-1:0]  out_ia_q, out_ib_q, out_ic_q;
	logic signed [POS_W-1:0]  out_ma_q, out_la_q;

	logic signed [OPA_W-1:0]  op_a;
	logic signed [OPB_W-1:0]  op_b;
	logic                     op_clr;
	logic                     op_neg;
	logic signed [24:0]       mul_a;
	logic signed [PP_W-1:0]   mul_p;
	logic signed [ACC_W-1:0]  pp_ext;
	logic signed [ACC_W-1:0]  addend;
	logic signed [OPA_W-1:0]  slip;
	logic signed [POS_W-1:0]  twist;

	logic signed [ACC_W-1:0]  sh8, sh14, sh16, sh24, sh30, sh32;
	logic signed [ACC_W-1:0]  w_ud, w_uq, w_tmp, w_ms, w_ls, w_st, w_te, w_tl, w_ia, w_ib;

	logic                     is_sine;
	logic [2:0]               sk;
	logic [TURN_W-1:0]        t_sel, t_rnd;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [QBITS-1:0]         xi;
	logic [SINE_TABLE_BITS-2:0] rom_addr;
	logic [30:0]              rom_data;
	logic signed [CUR_W-1:0]  sine_val;
	logic                     wb;

	assign stat.two_mass = mode_q;
	assign wb = cmd.run && (cmd.phase == PH_WB);

	// Operand selection for the current step
	assign slip  = OPA_W'(ms_q) - OPA_W'(ls_q);
	assign twist = ma_q - la_q;

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_clr = 1'b1;
		op_neg = 1'b0;
		case (cmd.step)
			ST_ANGLE:   begin op_a = OPA_W'(ma_q); op_b = K_TURN; end
			ST_PD0:     begin op_a = OPA_W'(ua_q); op_b = OPB_W'(sc_q[SC_C0]); end
			ST_PD1:     begin op_a = OPA_W'(ub_q); op_b = OPB_W'(sc_q[SC_C1]); op_clr = 1'b0; end
			ST_PD2:     begin op_a = OPA_W'(uc_q); op_b = OPB_W'(sc_q[SC_C2]); op_clr = 1'b0; end
			ST_UD:      begin op_a = tmp_q[OPA_W-1:0]; op_b = K_PARK; end
			ST_PQ0:     begin op_a = OPA_W'(ua_q); op_b = OPB_W'(sc_q[SC_S0]); end
			ST_PQ1:     begin op_a = OPA_W'(ub_q); op_b = OPB_W'(sc_q[SC_S1]); op_clr = 1'b0; end
			ST_PQ2:     begin op_a = OPA_W'(uc_q); op_b = OPB_W'(sc_q[SC_S2]); op_clr = 1'b0; end
			ST_UQ:      begin op_a = tmp_q[OPA_W-1:0]; op_b = K_PARK; end
			ST_XR:      begin op_a = OPA_W'(ms_q); op_b = K_PLQ; end
			ST_IDE:     begin op_a = OPA_W'(xr_q); op_b = OPB_W'(qcur_q); end
			ST_EMF:     begin op_a = OPA_W'(ms_q); op_b = K_FLUX; end
			ST_IQE:     begin op_a = OPA_W'(xr_q); op_b = OPB_W'(dcur_q); end
			ST_ID_DRV:  begin op_a = OPA_W'(ide_q) + OPA_W'(dprev_q); op_b = K_RECIP_KA; end
			ST_ID:      begin op_a = OPA_W'(dcur_q); op_b = K_KB_KA; end
			ST_IQ_DRV:  begin op_a = OPA_W'(iqe_q) + OPA_W'(qprev_q); op_b = K_RECIP_KA; end
			ST_IQ:      begin op_a = OPA_W'(qcur_q); op_b = K_KB_KA; end
			ST_IA0:     begin op_a = OPA_W'(dcur_q); op_b = OPB_W'(sc_q[SC_C0]); end
			ST_IA1:     begin
				op_a = OPA_W'(qcur_q); op_b = OPB_W'(sc_q[SC_S0]); op_clr = 1'b0; op_neg = 1'b1;
			end
			ST_IB0:     begin op_a = OPA_W'(dcur_q); op_b = OPB_W'(sc_q[SC_C1]); end
			ST_IB1:     begin
				op_a = OPA_W'(qcur_q); op_b = OPB_W'(sc_q[SC_S1]); op_clr = 1'b0; op_neg = 1'b1;
			end
			ST_T0:      begin op_a = OPA_W'(ia_q); op_b = OPB_W'(sc_q[SC_S0]); end
			ST_T1:      begin op_a = OPA_W'(ib_q); op_b = OPB_W'(sc_q[SC_S1]); op_clr = 1'b0; end
			ST_T2:      begin op_a = OPA_W'(ic_q); op_b = OPB_W'(sc_q[SC_S2]); op_clr = 1'b0; end
			ST_TE:      begin op_a = tmp_q[OPA_W-1:0]; op_b = K_FLUX; end
			ST_FR_HI:   begin op_a = OPA_W'(ms_q); op_b = {17'b0, fric_q[31:16]}; end
			ST_FR_LO:   begin op_a = OPA_W'(ms_q); op_b = {17'b0, fric_q[15:0]}; end
			ST_R_SPD:   begin op_a = OPA_W'(net_q); op_b = K_TS_J; end
			ST_R_POS:   begin op_a = OPA_W'(ms_q) + OPA_W'(msp_q); op_b = K_HALF_TS; end
			ST_E_MSPD:  begin op_a = OPA_W'(net_q); op_b = K_TS_JM; end
			ST_E_MPOS:  begin op_a = OPA_W'(ms_q); op_b = K_TS; end
			ST_E_LSPD:  begin op_a = OPA_W'(st_q); op_b = K_TS_JL; end
			ST_E_LPOS:  begin op_a = OPA_W'(ls_q); op_b = K_TS; end
			ST_SH_D_HI: begin op_a = slip; op_b = {17'b0, damp_q[31:16]}; end
			ST_SH_D_LO: begin op_a = slip; op_b = {17'b0, damp_q[15:0]}; end
			ST_SH_K_HI: begin op_a = OPA_W'(twist); op_b = {19'b0, stiff_q[29:16]}; end
			ST_SH_K_LO: begin op_a = OPA_W'(twist); op_b = {17'b0, stiff_q[15:0]}; end
			default:    begin op_a = '0; op_b = '0; end
		endcase
	end

	// Shared multiplier: low 24 bits of A first, then the signed upper part
	assign mul_a = (cmd.phase == PH_LO) ? $signed({1'b0, op_a[23:0]}) : op_a[OPA_W-1:24];
	assign mul_p = mul_a * op_b;

	assign pp_ext = (cmd.phase == PH_ACC) ? (ACC_W'(pp_s1) <<< 24) : ACC_W'(pp_s1);
	assign addend = op_neg ? -pp_ext : pp_ext;

	always_ff @(posedge clk) begin
		if (cmd.run && (cmd.phase == PH_LO || cmd.phase == PH_HI)) begin
			pp_s1 <= mul_p;
		end
		if (cmd.run && cmd.phase == PH_HI) begin
			acc_q <= (op_clr ? '0 : acc_q) + addend;
		end else if (cmd.run && cmd.phase == PH_ACC) begin
			acc_q <= acc_q + addend;
		end
	end

	// Sine lookup address from the turn fraction
	assign is_sine = (cmd.step >= ST_SIN0) && (cmd.step <= ST_SIN5);
	assign sk = 3'(cmd.step - ST_SIN0);

	always_comb begin
		case (sk)
			3'd1:    t_sel = t0_q - TURN_THIRD;
			3'd2:    t_sel = t0_q + TURN_THIRD;
			3'd3:    t_sel = t0_q + TURN_QUARTER;
			3'd4:    t_sel = t0_q + TURN_QUARTER - TURN_THIRD;
			3'd5:    t_sel = t0_q + TURN_QUARTER + TURN_THIRD;
			default: t_sel = t0_q;
		endcase
	end

	assign t_rnd = t_sel + ROUND_HALF;
	assign idx = t_rnd[TURN_W-1 -: SINE_TABLE_BITS];
	assign xi = idx[QBITS-1:0];
	assign rom_addr = idx[QBITS] ? (QSIZE - (SINE_TABLE_BITS-1)'(xi)) : (SINE_TABLE_BITS-1)'(xi);

	pmsm_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_rom (
		.clk (clk),
		.en  (cmd.run && is_sine && cmd.phase == PH_LO),
		.addr(rom_addr),
		.data(rom_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.run && is_sine && cmd.phase == PH_LO) begin
			neg_q <= idx[SINE_TABLE_BITS-1];
		end
	end

	assign sine_val = neg_q ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

	// Scaled accumulator views and widened operands for write-back
	assign sh8  = acc_q >>> 8;
	assign sh14 = acc_q >>> 14;
	assign sh16 = acc_q >>> 16;
	assign sh24 = acc_q >>> 24;
	assign sh30 = acc_q >>> 30;
	assign sh32 = acc_q >>> 32;
	assign w_ud  = ACC_W'(ud_q);
	assign w_uq  = ACC_W'(uq_q);
	assign w_tmp = ACC_W'(tmp_q);
	assign w_ms  = ACC_W'(ms_q);
	assign w_ls  = ACC_W'(ls_q);
	assign w_st  = ACC_W'(st_q);
	assign w_te  = ACC_W'(te_q);
	assign w_tl  = ACC_W'(tl_q);
	assign w_ia  = ACC_W'(ia_q);
	assign w_ib  = ACC_W'(ib_q);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			tl_q    <= '0;
			stiff_q <= STIFF_RST;
			damp_q  <= DAMP_RST;
			fric_q  <= FRIC_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_TWO_MASS:    mode_q  <= cfg_wdata[0];
				CFG_LOAD_TORQUE: tl_q    <= cfg_wdata[21:0];
				CFG_STIFFNESS:   stiff_q <= cfg_wdata[29:0];
				CFG_DAMPING:     damp_q  <= cfg_wdata;
				CFG_FRICTION:    fric_q  <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// Plant state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcur_q  <= '0;
			qcur_q  <= '0;
			dprev_q <= '0;
			qprev_q <= '0;
			ms_q    <= '0;
			msp_q   <= '0;
			ma_q    <= '0;
			ls_q    <= '0;
			la_q    <= '0;
			st_q    <= '0;
		end else if (wb) begin
			case (cmd.step)
				ST_ID_DRV:  dprev_q <= ide_q;
				ST_ID:      dcur_q  <= sat32((w_tmp + sh14) >>> 16);
				ST_IQ_DRV:  qprev_q <= iqe_q;
				ST_IQ:      qcur_q  <= sat32((w_tmp + sh14) >>> 16);
				ST_R_SPD:   ms_q    <= sat40(w_ms + sh32);
				ST_R_POS:   begin
					ma_q  <= ma_q + sh32[POS_W-1:0];
					msp_q <= ms_q;
				end
				ST_E_MSPD:  ms_q <= sat40(w_ms + sh32);
				ST_E_MPOS:  ma_q <= ma_q + sh32[POS_W-1:0];
				ST_E_LSPD:  ls_q <= sat40(w_ls + sh32);
				ST_E_LPOS:  la_q <= la_q + sh32[POS_W-1:0];
				ST_SH_K_LO: st_q <= sat32(w_tmp + sh24);
				default:    ;
			endcase
		end
	end

	// Working registers: input capture and per-step results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ua_q <= in_data[VOLT_W-1:0];
			ub_q <= in_data[2*VOLT_W-1:VOLT_W];
			uc_q <= in_data[3*VOLT_W-1:2*VOLT_W];
		end
		if (wb) begin
			case (cmd.step)
				ST_ANGLE:   t0_q <= acc_q[TURN_W-1:0];
				ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3, ST_SIN4, ST_SIN5: sc_q[sk] <= sine_val;
				ST_PD2:     tmp_q <= TMP_W'(sh30);
				ST_UD:      ud_q  <= sh30[CUR_W-1:0];
				ST_PQ2:     tmp_q <= TMP_W'(sh30);
				ST_UQ:      uq_q  <= CUR_W'(-sh30);
				ST_XR:      xr_q  <= sat32(sh24);
				ST_IDE:     ide_q <= sat32(w_ud + sh16);
				ST_EMF:     tmp_q <= TMP_W'(sh24);
				ST_IQE:     iqe_q <= sat32(w_uq - sh16 - w_tmp);
				ST_ID_DRV:  tmp_q <= TMP_W'(sh24);
				ST_IQ_DRV:  tmp_q <= TMP_W'(sh24);
				ST_IA1:     ia_q  <= sat32(sh30);
				ST_IB1:     ib_q  <= sat32(sh30);
				ST_T0:      ic_q  <= sat32(-(w_ia + w_ib));
				ST_T2:      tmp_q <= TMP_W'(sh30);
				ST_TE:      te_q  <= sat32(-sh24);
				ST_FR_HI:   tmp_q <= TMP_W'(sh16);
				ST_FR_LO:   net_q <= sat32(w_te - (mode_q ? w_st : '0) - w_tl - (w_tmp + sh32));
				ST_SH_D_HI: tmp_q <= TMP_W'(sh16);
				ST_SH_D_LO: tmp_q <= TMP_W'(w_tmp + sh32);
				ST_SH_K_HI: tmp_q <= TMP_W'(w_tmp + sh8);
				default:    ;
			endcase
		end
		// Hold the result word until the next item finishes
		if (cmd.finish) begin
			out_ia_q <= ia_q;
			out_ib_q <= ib_q;
			out_ic_q <= ic_q;
			out_ma_q <= ma_q;
			out_la_q <= mode_q ? la_q : '0;
		end
	end

	assign out_data = {out_la_q, out_ma_q, out_ic_q, out_ib_q, out_ia_q};

endmodule

// ----- rtl/pmsm_ctrl.sv -----
// Controller of the motor plant step: accepts a word, sequences the
// datapath steps and owns the output valid. Depends on pmsm_pkg, assert_macros.svh.
`include "assert_macros.svh"

module pmsm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  pmsm_pkg::stat_t stat,
	output pmsm_pkg::cmd_t  cmd
);
	import pmsm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t     state_q;
	step_t      step_q;
	step_t      step_next;
	logic [1:0] phase_q;
	logic       mvalid_q;
	logic       load;
	logic       finish;
	logic       last_step;

	assign s_tready = (state_q == S_IDLE);
	assign load     = s_tvalid && s_tready;
	assign finish   = (state_q == S_DONE) && (!mvalid_q || m_tready);
	assign m_tvalid = mvalid_q;

	// Branch into the mechanics of the selected mode
	always_comb begin
		case (step_q)
			ST_FR_LO: step_next = stat.two_mass ? ST_E_MSPD : ST_R_SPD;
			default:  step_next = step_t'(step_q + 6'd1);
		endcase
	end

	assign last_step = (step_q == ST_R_POS) || (step_q == ST_SH_K_LO);

	// Sequence states, steps and phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_ANGLE;
			phase_q <= PH_LO;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (load) begin
						state_q <= S_RUN;
						step_q  <= ST_ANGLE;
						phase_q <= PH_LO;
					end
				end
				S_RUN: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == PH_WB) begin
						if (last_step) begin
							state_q <= S_DONE;
						end else begin
							step_q <= step_next;
						end
					end
				end
				S_DONE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output valid: set on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (finish) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	assign cmd.load   = load;
	assign cmd.run    = (state_q == S_RUN);
	assign cmd.phase  = phase_q;
	assign cmd.step   = step_q;
	assign cmd.finish = finish;

	`ASSERT_NEXT(a_accept_start, load, state_q == S_RUN && step_q == ST_ANGLE && phase_q == PH_LO, "accepted word did not start at the angle step")
	`ASSERT_NEXT(a_step_hold, state_q == S_RUN && phase_q != PH_WB, step_q == $past(step_q), "step moved before its write-back phase")
	`ASSERT_NEXT(a_finish_valid, finish, mvalid_q, "finished word not presented")
	`ASSERT_IMPL(a_idle_phase, state_q == S_IDLE, phase_q == PH_LO, "phase not aligned while idle")

endmodule

// ----- rtl/pmsm_motor_plant_step.sv -----
// Top level of the PMSM plant step: controller and datapath.
// Depends on pmsm_pkg, pmsm_ctrl, pmsm_datapath.
//
// One input word is one 6.25 us tick of three phase voltages; one output word
// follows with the phase currents and the motor and load angles. Every multiply
// of the computation passes through a single shared 25x33 multiplier: the
// product is built in two halves, accumulated and then written back in a
// write-back phase. A tick takes 35 steps in single-mass mode and 41 in
// two-mass mode. A new word is taken only when the previous one has been
// computed; a finished word waits in the output register while the next one
// is accepted. Configuration registers must be written only while idle;
// nothing in the block itself enforces this.
module pmsm_motor_plant_step #(
	parameter int SINE_TABLE_BITS = pmsm_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: phase_a_voltage[25:0], phase_b_voltage[51:26],
	//          phase_c_voltage[77:52], zero[79:78]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pmsm_pkg::IN_W-1:0]     s_tdata,
	// m_tdata: phase_a_current[31:0], phase_b_current[63:32],
	//          phase_c_current[95:64], motor_position[143:96],
	//          load_position[191:144]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pmsm_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_we,
	input  logic [pmsm_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [pmsm_pkg::CFG_W-1:0]    cfg_wdata
);
	import pmsm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pmsm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	pmsm_datapath #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.out_data (m_tdata)
	);

endmodule

// ----- bench/pmsm_motor_plant_step_test.sv -----
// Self-checking bench for the PMSM plant step: drives voltage ticks and checks
// phase currents and positions against an in-bench fixed-point plant model.
// Depends on pmsm_pkg and pmsm_motor_plant_step.
`timescale 1ns / 1ps

module pmsm_motor_plant_step_test;

	import pmsm_pkg::*;

	localparam int TBL_BITS = SINE_TABLE_BITS_DEF;
	localparam int STALL_LIMIT = 20000;

	// Plant constants
	localparam longint unsigned TURN_GAIN = 64'd2734261104;
	localparam longint unsigned THIRD_Q56 = 64'd24019198012642645;
	localparam longint unsigned QUARTER_Q56 = 64'd18014398509481984;
	localparam longint PARK_GAIN = 715831462;
	localparam longint PLQ_GAIN = 246289;
	localparam longint FLUX_GAIN = 3163512;
	localparam longint RECIP_KA = 933926466;
	localparam longint KB_KA = 1068452006;
	localparam longint TS_OVER_J = 95325090;
	localparam longint TS_OVER_JM = 610080582;
	localparam longint TS_OVER_JL = 112977886;
	localparam longint TS_GAIN = 6871948;
	localparam longint HALF_TS_GAIN = 3435974;
	localparam longint VOLT_MAX = 19660800;

	typedef struct {
		logic [31:0] ia;
		logic [31:0] ib;
		logic [31:0] ic;
		logic [47:0] mpos;
		logic [47:0] lpos;
	} plant_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int quiet_cycles = 0;
	plant_out_t expected_out[$];

	// Plant state and register mirror
	longint d_cur, q_cur, d_drv_prev, q_drv_prev;
	longint m_spd, m_spd_prev, m_ang, l_spd, l_ang, sh_trq;
	longint unsigned mode_reg, ltrq_reg, stiff_reg, damp_reg, fric_reg;

	pmsm_motor_plant_step DUT (.*);

	always #5 clk = ~clk;

	function automatic longint sext_w(longint unsigned v, int w);
		longint unsigned m;
		m = (64'd1 << w) - 1;
		v = v & m;
		if (v[w-1]) return longint'(v | ~m);
		return longint'(v);
	endfunction

	function automatic longint sat_w(longint v, int w);
		longint lim;
		lim = 64'sd1 <<< (w - 1);
		if (v > lim - 1) return lim - 1;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint frac_mul(longint v, longint unsigned c, int s);
		longint hi, lo;
		hi = v * longint'((c >> 16) & 64'hFFFF);
		lo = v * longint'(c & 64'hFFFF);
		return (hi >>> (s - 16)) + (lo >>> s);
	endfunction

	function automatic longint quad_sine(longint x);
		longint x2, p;
		x2 = (x * x) >>> 30;
		p = 61;
		p = -3864 + ((p * x2) >>> 30);
		p = 172272 + ((p * x2) >>> 30);
		p = -5026995 + ((p * x2) >>> 30);
		p = 85569306 + ((p * x2) >>> 30);
		p = -693598669 + ((p * x2) >>> 30);
		p = 1686629713 + ((p * x2) >>> 30);
		p = (p * x) >>> 30;
		if (p > (64'sd1 <<< 30)) p = 64'sd1 <<< 30;
		if (p < 0) p = 0;
		return p;
	endfunction

	// Sine of a Q56 turn fraction, Q30 result
	function automatic longint turn_sine(longint unsigned t);
		longint unsigned idx, quad, qsz;
		longint x, r;
		idx = ((t + (64'd1 << (55 - TBL_BITS))) >> (56 - TBL_BITS))
			& ((64'd1 << TBL_BITS) - 1);
		quad = idx >> (TBL_BITS - 2);
		qsz = 64'd1 << (TBL_BITS - 2);
		x = longint'((idx & (qsz - 1)) << (30 - (TBL_BITS - 2)));
		r = quad[0] ? quad_sine((64'sd1 <<< 30) - x) : quad_sine(x);
		return quad[1] ? -r : r;
	endfunction

	// Advance the plant one tick and return the expected output word
	function automatic plant_out_t plant_tick(longint ua, longint ub, longint uc);
		longint unsigned t0, tm, tp;
		longint s0, s1, s2, c0, c1, c2;
		longint ud, uq, xr, ide, iqe, id, iq, ia, ib, ic, tsum, te, tl, fric, net;
		longint twist, slip;
		plant_out_t r;
		t0 = longint'(m_ang) * TURN_GAIN;
		tm = t0 - THIRD_Q56;
		tp = t0 + THIRD_Q56;
		s0 = turn_sine(t0);
		s1 = turn_sine(tm);
		s2 = turn_sine(tp);
		c0 = turn_sine(t0 + QUARTER_Q56);
		c1 = turn_sine(tm + QUARTER_Q56);
		c2 = turn_sine(tp + QUARTER_Q56);
		ud = (((ua * c0 + ub * c1 + uc * c2) >>> 30) * PARK_GAIN) >>> 30;
		uq = -((((ua * s0 + ub * s1 + uc * s2) >>> 30) * PARK_GAIN) >>> 30);
		xr = sat_w((m_spd * PLQ_GAIN) >>> 24, 32);
		ide = sat_w(ud + ((xr * q_cur) >>> 16), 32);
		iqe = sat_w(uq - ((xr * d_cur) >>> 16) - ((m_spd * FLUX_GAIN) >>> 24), 32);
		id = sat_w(((((ide + d_drv_prev) * RECIP_KA) >>> 24)
			+ ((d_cur * KB_KA) >>> 14)) >>> 16, 32);
		iq = sat_w(((((iqe + q_drv_prev) * RECIP_KA) >>> 24)
			+ ((q_cur * KB_KA) >>> 14)) >>> 16, 32);
		d_drv_prev = ide;
		q_drv_prev = iqe;
		d_cur = id;
		q_cur = iq;
		ia = sat_w((id * c0 - iq * s0) >>> 30, 32);
		ib = sat_w((id * c1 - iq * s1) >>> 30, 32);
		ic = sat_w(-(ia + ib), 32);
		tsum = (ia * s0 + ib * s1 + ic * s2) >>> 30;
		te = sat_w(-((tsum * FLUX_GAIN) >>> 24), 32);
		tl = sext_w(ltrq_reg, 22);
		fric = frac_mul(m_spd, fric_reg, 32);
		if (mode_reg == 0) begin
			net = sat_w(te - tl - fric, 32);
			m_spd = sat_w(m_spd + ((net * TS_OVER_J) >>> 32), 40);
			m_ang = sext_w(m_ang + (((m_spd + m_spd_prev) * HALF_TS_GAIN) >>> 32), 48);
			m_spd_prev = m_spd;
		end else begin
			net = sat_w(te - sh_trq - tl - fric, 32);
			m_spd = sat_w(m_spd + ((net * TS_OVER_JM) >>> 32), 40);
			m_ang = sext_w(m_ang + ((m_spd * TS_GAIN) >>> 32), 48);
			l_spd = sat_w(l_spd + ((sh_trq * TS_OVER_JL) >>> 32), 40);
			l_ang = sext_w(l_ang + ((l_spd * TS_GAIN) >>> 32), 48);
			twist = sext_w(m_ang - l_ang, 48);
			slip = m_spd - l_spd;
			sh_trq = sat_w(frac_mul(slip, damp_reg, 32)
				+ frac_mul(twist, stiff_reg, 24), 32);
		end
		r.ia = ia[31:0];
		r.ib = ib[31:0];
		r.ic = ic[31:0];
		r.mpos = m_ang[47:0];
		r.lpos = (mode_reg != 0) ? l_ang[47:0] : '0;
		return r;
	endfunction

	// Send one voltage word, idling first at the current rate
	task automatic send_tick(input longint va, input longint vb, input longint vc);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, vc[25:0], vb[25:0], va[25:0]};
		do @(posedge clk); while (!s_tready);
		expected_out.push_back(plant_tick(va, vb, vc));
	endtask

	// Drop valid and wait until every expected word has come back
	task automatic drain;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_out.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write one register, then deassert the write enable before the next write
	task automatic write_reg(input cfg_idx_t idx, input longint unsigned val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[31:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TWO_MASS:    mode_reg = val & 64'h1;
			CFG_LOAD_TORQUE: ltrq_reg = val & 64'h3FFFFF;
			CFG_STIFFNESS:   stiff_reg = val & 64'h3FFFFFFF;
			CFG_DAMPING:     damp_reg = val & 64'hFFFFFFFF;
			CFG_FRICTION:    fric_reg = val & 64'hFFFFFFFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic longint rand_volt();
		case ($urandom_range(7))
			0: return VOLT_MAX;
			1: return -VOLT_MAX;
			2: return longint'($urandom_range(655360)) - 327680;
			default: return longint'($urandom_range(2 * VOLT_MAX)) - VOLT_MAX;
		endcase
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_tick(rand_volt(), rand_volt(), rand_volt());
	endtask

	// Extremes of the voltages in both mechanical modes
	task automatic test_directed;
		send_tick(0, 0, 0);
		send_tick(VOLT_MAX, VOLT_MAX, VOLT_MAX);
		send_tick(-VOLT_MAX, -VOLT_MAX, -VOLT_MAX);
		send_tick(VOLT_MAX, -VOLT_MAX, 0);
		send_tick(-VOLT_MAX, 0, VOLT_MAX);
		send_random(5);
		drain();
		write_reg(CFG_TWO_MASS, 1);
		send_tick(VOLT_MAX, -VOLT_MAX, 0);
		send_tick(0, VOLT_MAX, -VOLT_MAX);
		send_tick(-VOLT_MAX, -VOLT_MAX, -VOLT_MAX);
		send_random(5);
		// mode change keeps state
		drain();
		write_reg(CFG_TWO_MASS, 0);
		send_random(3);
		drain();
	endtask

	// Register extremes, including values past the documented range
	task automatic test_register_extremes;
		write_reg(CFG_LOAD_TORQUE, 1310720);
		write_reg(CFG_FRICTION, 0);
		send_random(4);
		drain();
		write_reg(CFG_LOAD_TORQUE, 64'hFFEC0000);
		write_reg(CFG_FRICTION, 64'hFFFFFFFF);
		write_reg(CFG_TWO_MASS, 1);
		write_reg(CFG_STIFFNESS, 0);
		write_reg(CFG_DAMPING, 64'hFFFFFFFF);
		send_random(4);
		drain();
		write_reg(CFG_STIFFNESS, 64'h3FFFFFFF);
		write_reg(CFG_DAMPING, 0);
		write_reg(CFG_LOAD_TORQUE, 64'h3FFFFF);
		send_random(4);
		drain();
	endtask

	// Random ticks under one idling pattern, with a mid-run drain
	task automatic test_random_phase(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_reg(CFG_TWO_MASS, $urandom_range(1));
		write_reg(CFG_LOAD_TORQUE, $urandom_range(7) == 0 ? longint'($urandom)
			: longint'($urandom_range(2621440)) - 1310720);
		write_reg(CFG_STIFFNESS, $urandom_range(3) == 0 ? longint'($urandom)
			: longint'($urandom_range(655360000)));
		write_reg(CFG_DAMPING, $urandom);
		write_reg(CFG_FRICTION, $urandom);
		send_random(90);
		drain();
		send_random(90);
		drain();
	endtask

	// Receiver stalls at the current rate
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare each output word with the oldest expectation
	always @(posedge clk) begin
		plant_out_t e;
		if (m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				$error("unexpected output word %h", m_tdata);
				err_count++;
			end else begin
				e = expected_out.pop_front();
				if (m_tdata[31:0] !== e.ia) begin
					$error("phase_a_current exp %h got %h", e.ia, m_tdata[31:0]);
					err_count++;
				end
				if (m_tdata[63:32] !== e.ib) begin
					$error("phase_b_current exp %h got %h", e.ib, m_tdata[63:32]);
					err_count++;
				end
				if (m_tdata[95:64] !== e.ic) begin
					$error("phase_c_current exp %h got %h", e.ic, m_tdata[95:64]);
					err_count++;
				end
				if (m_tdata[143:96] !== e.mpos) begin
					$error("motor_position exp %h got %h", e.mpos, m_tdata[143:96]);
					err_count++;
				end
				if (m_tdata[191:144] !== e.lpos) begin
					$error("load_position exp %h got %h", e.lpos, m_tdata[191:144]);
					err_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("pmsm_motor_plant_step_test NOT OK");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		d_cur = 0; q_cur = 0; d_drv_prev = 0; q_drv_prev = 0;
		m_spd = 0; m_spd_prev = 0; m_ang = 0; l_spd = 0; l_ang = 0; sh_trq = 0;
		mode_reg = 0; ltrq_reg = 0;
		stiff_reg = 327680000; damp_reg = 858993; fric_reg = 4294967;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_phase(0, 0);
		test_random_phase(64, 0);
		test_random_phase(0, 64);
		test_random_phase(9, 9);
		drain();
		repeat (200) @(posedge clk);
		if (err_count == 0 && expected_out.size() == 0)
			$display("pmsm_motor_plant_step_test OK");
		else
			$display("pmsm_motor_plant_step_test NOT OK");
		$finish;
	end

endmodule

// ----- pmsm_motor_plant_step.f -----
+incdir+rtl
rtl/pmsm_pkg.sv
rtl/pmsm_sine_rom.sv
rtl/pmsm_datapath.sv
rtl/pmsm_ctrl.sv
rtl/pmsm_motor_plant_step.sv
bench/pmsm_motor_plant_step_test.sv
